@@ hw/rtl/lifna_pkg.sv @@
// Shared types and constants for the LIF neuron array update core.
// Request/result payloads, configuration set, table entry and op codes.
// No dependencies.
package lifna_pkg;

  // Op codes of the input request
  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_INJECT  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RESTING   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd6;

  localparam int unsigned CFG_DATA_W = 16;

  // Input request payload
  typedef struct packed {
    logic               opcode;
    logic [7:0]         neuron_index;
    logic signed [15:0] current;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic [7:0]         neuron_index_res;
    logic               spiked;
    logic               refractory;
    logic signed [15:0] potential;
    logic [31:0]        total_spikes;
  } out_res_t;

  // Configuration register set
  typedef struct packed {
    logic signed [15:0] resting_potential;
    logic signed [15:0] reset_potential;
    logic signed [15:0] threshold_potential;
    logic [15:0]        leak_gain;
    logic [7:0]         refractory_ticks;
    logic signed [15:0] potential_floor;
    logic signed [15:0] potential_ceiling;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    resting_potential:   16'shBA00,  // -70 mV
    reset_potential:     16'shBF00,  // -65 mV
    threshold_potential: 16'shC900,  // -55 mV
    leak_gain:           16'h0CCD,
    refractory_ticks:    8'd2,
    potential_floor:     16'sh9C00,  // -100 mV
    potential_ceiling:   16'shD800   // -40 mV
  };

  // One neuron table entry
  typedef struct packed {
    logic [7:0]         ticks;
    logic signed [15:0] membrane;
  } neuron_t;

  localparam int unsigned ENTRY_W = $bits(neuron_t);

  localparam neuron_t ENTRY_RESET = '{ticks: 8'hFF, membrane: 16'shBA00};

  // Datapath result toward the top level
  typedef struct packed {
    neuron_t entry;
    logic    spiked;
    logic    refractory;
  } dp_res_t;

endpackage

@@ hw/rtl/lifna_mem.sv @@
// Neuron state table: one write port, one read port with registered data.
// Depends on lifna_pkg for the entry type.
module lifna_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  lifna_pkg::neuron_t wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output lifna_pkg::neuron_t rdata_r
);

  lifna_pkg::neuron_t mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

@@ hw/rtl/lifna_dp.sv @@
// Single-neuron update datapath: leak, clamp, threshold, refractory, inject.
// Depends on lifna_pkg for configuration, entry and result types.
module lifna_dp (
  input  lifna_pkg::cfg_t    cfg,
  input  logic               opcode,
  input  logic signed [15:0] current,
  input  lifna_pkg::neuron_t entry,
  output lifna_pkg::dp_res_t res
);

  logic [7:0]         t_inc;
  logic               in_refr;
  logic signed [17:0] diff;
  logic signed [34:0] prod;
  logic signed [18:0] delta;
  logic signed [19:0] x_raw;
  logic signed [19:0] lo;
  logic signed [19:0] hi;
  logic signed [19:0] x_clamp;
  logic signed [15:0] v_leak;
  logic               fire;
  logic signed [16:0] inj_sum;
  logic signed [15:0] inj_sat;

  // tick counter saturates at 255
  assign t_inc   = (entry.ticks == 8'hFF) ? entry.ticks : entry.ticks + 8'd1;
  assign in_refr = (t_inc < cfg.refractory_ticks);

  // leak toward rest: gain * (rest - V + I), floored back to Q8.8
  assign diff  = 18'(cfg.resting_potential) - 18'(entry.membrane) + 18'(current);
  assign prod  = 35'(diff) * 35'($signed({1'b0, cfg.leak_gain}));
  assign delta = prod[34:16];
  assign x_raw = 20'(entry.membrane) + 20'(delta);

  // clamp; floor wins for values below it, also with floor above ceiling
  assign lo = 20'(cfg.potential_floor);
  assign hi = 20'(cfg.potential_ceiling);
  always_comb begin
    priority if (x_raw < lo) begin
      x_clamp = lo;
    end else if (!(x_raw < hi)) begin
      x_clamp = hi;
    end else begin
      x_clamp = x_raw;
    end
  end
  assign v_leak = x_clamp[15:0];
  assign fire   = (v_leak >= cfg.threshold_potential);

  // inject with 16-bit saturation
  assign inj_sum = 17'(entry.membrane) + 17'(current);
  always_comb begin
    priority if (inj_sum > 17'sd32767) begin
      inj_sat = 16'sh7FFF;
    end else if (inj_sum < -17'sd32768) begin
      inj_sat = 16'sh8000;
    end else begin
      inj_sat = inj_sum[15:0];
    end
  end

  // select the new entry
  always_comb begin
    res = '0;
    unique case (opcode)
      lifna_pkg::OP_ADVANCE: begin
        if (in_refr) begin
          res.entry.ticks    = t_inc;
          res.entry.membrane = cfg.reset_potential;
          res.refractory     = 1'b1;
        end else if (fire) begin
          res.entry.ticks    = 8'd0;
          res.entry.membrane = cfg.reset_potential;
          res.spiked         = 1'b1;
        end else begin
          res.entry.ticks    = t_inc;
          res.entry.membrane = v_leak;
        end
      end
      lifna_pkg::OP_INJECT: begin
        res.entry.ticks    = entry.ticks;
        res.entry.membrane = inj_sat;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/lif_neuron_array_update_core.sv @@
// A request passes the registered table read and the update stage register,
// then enters the result register when it is empty or its result is taken.
// Throughput: one request per cycle while the result register drains and no
// clearing pass runs; table read is registered, a one-deep bypass covers
// back-to-back requests to the same neuron. Reset: synchronous active-low
// rst_n restores the registers and starts a clearing pass over the table;
// in_ready stays low during it, configuration writes are taken throughout.
module lif_neuron_array_update_core #(
  parameter int NEURON_COUNT = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lifna_pkg::in_req_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lifna_pkg::out_res_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lifna_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lifna_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;

  lifna_pkg::cfg_t    cfg_r;
  logic               clr_active_r;
  logic [AW-1:0]      clr_cnt_r;
  logic               s1_valid_r;
  lifna_pkg::in_req_t s1_req_r;
  logic               fwd_r;
  lifna_pkg::neuron_t wb_entry_r;
  logic [31:0]        spike_total_r;
  logic [31:0]        spike_total_nxt;
  lifna_pkg::out_res_t out_data_r;
  lifna_pkg::out_res_t out_data_nxt;
  logic               out_valid_r;

  logic               in_fire;
  logic               s1_adv;
  logic               s1_fire;
  logic               s1_in_range;
  lifna_pkg::neuron_t rd_entry;
  lifna_pkg::neuron_t op_entry;
  lifna_pkg::dp_res_t dp_res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  lifna_pkg::neuron_t mem_wdata;

  // handshakes
  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_ready  = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_fire   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lifna_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lifna_pkg::REG_RESTING:   cfg_r.resting_potential   <= cfg_wdata;
        lifna_pkg::REG_RESET:     cfg_r.reset_potential     <= cfg_wdata;
        lifna_pkg::REG_THRESHOLD: cfg_r.threshold_potential <= cfg_wdata;
        lifna_pkg::REG_LEAK_GAIN: cfg_r.leak_gain           <= cfg_wdata;
        lifna_pkg::REG_REFRACT:   cfg_r.refractory_ticks    <= cfg_wdata[7:0];
        lifna_pkg::REG_FLOOR:     cfg_r.potential_floor     <= cfg_wdata;
        lifna_pkg::REG_CEILING:   cfg_r.potential_ceiling   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clearing pass over the table after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(NEURON_COUNT - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // table write port: clearing pass or write-back of the update
  assign s1_in_range = (32'(s1_req_r.neuron_index) < NEURON_COUNT);
  assign mem_we      = clr_active_r || (s1_fire && s1_in_range);
  assign mem_waddr   = clr_active_r ? clr_cnt_r : AW'(s1_req_r.neuron_index);
  assign mem_wdata   = clr_active_r ? lifna_pkg::ENTRY_RESET : dp_res.entry;

  lifna_mem #(
    .DEPTH (NEURON_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (in_fire),
    .raddr   (AW'(in_data.neuron_index)),
    .rdata_r (rd_entry)
  );

  // update stage register with write-back bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
      fwd_r      <= s1_valid_r && s1_in_range &&
                    (s1_req_r.neuron_index == in_data.neuron_index);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_data;
    end
    if (s1_fire) begin
      wb_entry_r <= dp_res.entry;
    end
  end

  assign op_entry = fwd_r ? wb_entry_r : rd_entry;

  lifna_dp u_dp (
    .cfg     (cfg_r),
    .opcode  (s1_req_r.opcode),
    .current (s1_req_r.current),
    .entry   (op_entry),
    .res     (dp_res)
  );

  // spike counter and result assembly
  always_comb begin
    spike_total_nxt = spike_total_r;
    if (s1_in_range && dp_res.spiked) begin
      spike_total_nxt = spike_total_r + 32'd1;
    end
    out_data_nxt                  = '0;
    out_data_nxt.neuron_index_res = s1_req_r.neuron_index;
    out_data_nxt.total_spikes     = spike_total_nxt;
    if (s1_in_range) begin
      out_data_nxt.spiked     = dp_res.spiked;
      out_data_nxt.refractory = dp_res.refractory;
      out_data_nxt.potential  = dp_res.entry.membrane;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spike_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else if (s1_fire) begin
      spike_total_r <= spike_total_nxt;
      out_valid_r   <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no request is taken while the table is being cleared
  a_clr_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_ready)
    else $error("request accepted during table clearing");

  // bypass only ever points at a live update stage
  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("bypass set without an item in the update stage");

  // spike total moves only on a spiking update, by one
  a_spike_step: assert property (@(posedge clk) disable iff (!rst_n)
    (spike_total_r != $past(spike_total_r)) |->
      ($past(s1_fire && s1_in_range && dp_res.spiked) &&
       (spike_total_r == $past(spike_total_r) + 32'd1)))
    else $error("spike total changed without a spike");

  // a result never reports spiking and refractory together
  a_spike_refr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.spiked && out_data.refractory))
    else $error("result both spiked and refractory");

endmodule

@@ verif/tb.sv @@
// Self-checking bench for lif_neuron_array_update_core: directed table, then random phases.
// Predicts each untyped result from its own copy of the neuron table and config registers.
// Depends on lifna_pkg and the core RTL only.
module tb;

  localparam int NEURONS = 256;

  // Clock, reset and DUT ports
  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  lifna_pkg::in_req_t   in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  lifna_pkg::out_res_t  out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [lifna_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lifna_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  lif_neuron_array_update_core #(
    .NEURON_COUNT(NEURONS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Directed stimulus rows
  typedef enum logic {ROW_REQUEST, ROW_REG_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    lifna_pkg::in_req_t              req;
    logic [lifna_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [15:0]                     reg_val;
    bit                              typed;
    lifna_pkg::out_res_t             want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  // Predictor state: membrane table, tick counters, spike total, registers
  logic signed [15:0] v_table    [NEURONS];
  logic [7:0]         tick_table [NEURONS];
  logic [31:0]        spike_count = '0;
  lifna_pkg::cfg_t    lif_cfg = lifna_pkg::CFG_RESET;

  lifna_pkg::out_res_t pending_results[$];

  // Bookkeeping
  int  n_errors = 0;
  int  n_requests = 0;
  int  n_directed = 0;
  int  n_results = 0;
  int  n_reg_writes = 0;
  bit  idle_on = 1'b0;
  int  hold_reqs = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One LIF step of the addressed neuron; updates the predictor state
  function automatic lifna_pkg::out_res_t neuron_update(lifna_pkg::in_req_t r);
    lifna_pkg::out_res_t res;
    logic [7:0]          t;
    longint              v, x, lo, hi;
    res = '0;
    res.neuron_index_res = r.neuron_index;
    if (int'(r.neuron_index) < NEURONS) begin
      v = longint'(v_table[r.neuron_index]);
      if (r.opcode == lifna_pkg::OP_ADVANCE) begin
        t = tick_table[r.neuron_index];
        if (t != 8'hFF) t = t + 8'd1;
        if (t < lif_cfg.refractory_ticks) begin
          v = longint'($signed(lif_cfg.reset_potential));
          res.refractory = 1'b1;
        end else begin
          lo = longint'($signed(lif_cfg.potential_floor));
          hi = longint'($signed(lif_cfg.potential_ceiling));
          x = longint'($signed(lif_cfg.resting_potential)) - v + longint'($signed(r.current));
          // Q8.24 product, floor shift back to Q8.8
          x = v + ((x * longint'(lif_cfg.leak_gain)) >>> 16);
          if (x < lo) x = lo;
          else if (x >= hi) x = hi;
          v = x;
          if (v >= longint'($signed(lif_cfg.threshold_potential))) begin
            res.spiked = 1'b1;
            t = 8'd0;
            v = longint'($signed(lif_cfg.reset_potential));
            spike_count = spike_count + 32'd1;
          end
        end
        tick_table[r.neuron_index] = t;
      end else begin
        // inject: saturating add, no spike check
        v = v + longint'($signed(r.current));
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      v_table[r.neuron_index] = 16'(v);
      res.potential = 16'(v);
    end
    res.total_spikes = spike_count;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                n_results, name, got, want));
  endtask

  task automatic check_result(lifna_pkg::out_res_t got);
    lifna_pkg::out_res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result for neuron %0d with nothing expected",
                                got.neuron_index_res));
    end else begin
      want = pending_results.pop_front();
      check_field("neuron_index_res", got.neuron_index_res, want.neuron_index_res);
      check_field("spiked", got.spiked, want.spiked);
      check_field("refractory", got.refractory, want.refractory);
      check_field("potential", got.potential, want.potential);
      check_field("total_spikes", got.total_spikes, want.total_spikes);
      n_results++;
    end
  endtask

  // Result side: check accepted results, then drive ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one request, wait for the handshake, record what should come back
  task automatic send_request(lifna_pkg::in_req_t r, bit typed,
                              lifna_pkg::out_res_t typed_res);
    lifna_pkg::out_res_t want;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = neuron_update(r);
    if (typed) want = typed_res;
    pending_results.push_back(want);
    n_requests++;
  endtask

  // Stop offering and let every outstanding result drain
  task automatic wait_idle();
    if (pending_results.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  // Register write; caller drops cfg_valid after the last one of a batch
  task automatic write_reg(logic [lifna_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lifna_pkg::REG_RESTING:   lif_cfg.resting_potential   = val;
      lifna_pkg::REG_RESET:     lif_cfg.reset_potential     = val;
      lifna_pkg::REG_THRESHOLD: lif_cfg.threshold_potential = val;
      lifna_pkg::REG_LEAK_GAIN: lif_cfg.leak_gain           = val;
      lifna_pkg::REG_REFRACT:   lif_cfg.refractory_ticks    = val[7:0];
      lifna_pkg::REG_FLOOR:     lif_cfg.potential_floor     = val;
      lifna_pkg::REG_CEILING:   lif_cfg.potential_ceiling   = val;
      default: ;
    endcase
    n_reg_writes++;
  endtask

  task automatic set_config(int rest, int reset_v, int thr, int gain, int refr,
                            int lo, int hi);
    wait_idle();
    write_reg(lifna_pkg::REG_RESTING, 16'(rest));
    write_reg(lifna_pkg::REG_RESET, 16'(reset_v));
    write_reg(lifna_pkg::REG_THRESHOLD, 16'(thr));
    write_reg(lifna_pkg::REG_LEAK_GAIN, 16'(gain));
    write_reg(lifna_pkg::REG_REFRACT, 16'(refr));
    write_reg(lifna_pkg::REG_FLOOR, 16'(lo));
    write_reg(lifna_pkg::REG_CEILING, 16'(hi));
    cfg_valid <= 1'b0;
  endtask

  task automatic add_request(logic op, int idx, int cur, bit typed = 1'b0,
                             bit spk = 1'b0, bit rfr = 1'b0, int pot = 0,
                             int unsigned total = 0);
    stim_row_t row;
    row = '{kind: ROW_REQUEST, default: '0};
    row.req.opcode = op;
    row.req.neuron_index = 8'(idx);
    row.req.current = 16'(cur);
    row.typed = typed;
    row.want.neuron_index_res = 8'(idx);
    row.want.spiked = spk;
    row.want.refractory = rfr;
    row.want.potential = 16'(pot);
    row.want.total_spikes = total;
    directed_rows.push_back(row);
  endtask

  task automatic add_reg_write(logic [lifna_pkg::CFG_IDX_W-1:0] idx, int val);
    stim_row_t row;
    row = '{kind: ROW_REG_WRITE, default: '0};
    row.reg_idx = idx;
    row.reg_val = 16'(val);
    directed_rows.push_back(row);
  endtask

  // Mostly repeated steps on a few neurons so they charge, fire and recover
  function automatic lifna_pkg::in_req_t random_request(int hot_base, int hot_n);
    lifna_pkg::in_req_t r;
    r.opcode = ($urandom_range(0, 4) == 0) ? lifna_pkg::OP_INJECT : lifna_pkg::OP_ADVANCE;
    if ($urandom_range(0, 9) < 8)
      r.neuron_index = 8'(hot_base + int'($urandom_range(0, hot_n - 1)));
    else
      r.neuron_index = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: r.current = 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: r.current = 16'sh7FFF;
          1: r.current = 16'sh8000;
          2: r.current = '0;
          default: r.current = '1;
        endcase
      end
      default: r.current = 16'(int'($urandom_range(0, 12000)) - 3000);
    endcase
    return r;
  endfunction

  task automatic run_phase(int n_items, bit idle, bit long_hold, bit mid_pause);
    int hot_base, hot_n;
    hot_n = $urandom_range(2, 12);
    hot_base = $urandom_range(0, NEURONS - hot_n);
    for (int i = 0; i < n_items; i++) begin
      idle_on = idle && !(i >= 40 && i < 80);
      if (i == n_items / 2) begin
        // receiver holds off while requests keep coming, or all results drain
        if (long_hold) hold_reqs <= hold_reqs + 1;
        if (mid_pause) wait_idle();
      end
      send_request(random_request(hot_base, hot_n), 1'b0, '0);
    end
  endtask

  function automatic int bio_rest();
    return -int'($urandom_range(15000, 20000));
  endfunction

  // Main sequence
  initial begin
    int rest, thr;
    for (int k = 0; k < NEURONS; k++) begin
      v_table[k] = lifna_pkg::CFG_RESET.resting_potential;
      tick_table[k] = 8'hFF;
    end

    // Defaults after reset: first step, injects, saturation, spike, refractory
    add_request(lifna_pkg::OP_ADVANCE, 0, 0, 1, 0, 0, -17920, 0);
    add_request(lifna_pkg::OP_INJECT, 255, 32767, 1, 0, 0, 14847, 0);
    add_request(lifna_pkg::OP_INJECT, 255, 32767, 1, 0, 0, 32767, 0);
    add_request(lifna_pkg::OP_INJECT, 254, -32768, 1, 0, 0, -32768, 0);
    add_request(lifna_pkg::OP_ADVANCE, 255, 0, 1, 1, 0, -16640, 1);
    add_request(lifna_pkg::OP_ADVANCE, 255, 0, 1, 0, 1, -16640, 1);
    add_request(lifna_pkg::OP_ADVANCE, 255, 0);
    add_request(lifna_pkg::OP_ADVANCE, 254, -32768, 1, 0, 0, -25600, 1);
    add_request(lifna_pkg::OP_ADVANCE, 1, 32767);
    add_request(lifna_pkg::OP_ADVANCE, 1, -32768);
    add_request(lifna_pkg::OP_INJECT, 2, 0, 1, 0, 0, -17920, 1);
    add_request(lifna_pkg::OP_ADVANCE, 128, -1);
    add_request(lifna_pkg::OP_INJECT, 170, 21845);
    add_request(lifna_pkg::OP_ADVANCE, 85, -21846);
    // Floor above ceiling, longest refractory: saturated counter is not refractory
    add_reg_write(lifna_pkg::REG_FLOOR, 32767);
    add_reg_write(lifna_pkg::REG_CEILING, -32768);
    add_reg_write(lifna_pkg::REG_REFRACT, 255);
    add_request(lifna_pkg::OP_ADVANCE, 3, 0, 1, 1, 0, -16640, 2);
    add_request(lifna_pkg::OP_ADVANCE, 3, 0, 1, 0, 1, -16640, 2);
    add_request(lifna_pkg::OP_ADVANCE, 4, 0, 1, 1, 0, -16640, 3);
    // Value at or above an inverted floor lands on the ceiling
    add_reg_write(lifna_pkg::REG_FLOOR, -20000);
    add_reg_write(lifna_pkg::REG_CEILING, -30000);
    add_reg_write(lifna_pkg::REG_THRESHOLD, 32767);
    add_request(lifna_pkg::OP_ADVANCE, 5, 0, 1, 0, 0, -30000, 3);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    idle_on = 1'b1;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_REG_WRITE) begin
        wait_idle();
        write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        send_request(directed_rows[k].req, directed_rows[k].typed,
                     directed_rows[k].want);
      end
    end
    n_directed = n_requests;

    // Default potentials, random leak and refractory period
    set_config(-17920, -16640, -14080, $urandom_range(1500, 9000), $urandom_range(0, 4),
               -25600, -10240);
    run_phase(180, 1'b1, 1'b0, 1'b0);

    // Extremes: every non-refractory step fires, top gain and refractory, inverted clamp
    set_config(32767, -32768, -32768, 65535, 255, 32767, -32768);
    run_phase(180, 1'b1, 1'b0, 1'b0);

    // Extremes: no leak, no refractory, widest clamp, top threshold
    set_config(-32768, 32767, 32767, 0, 0, -32768, 32767);
    run_phase(180, 1'b1, 1'b0, 1'b0);

    rest = bio_rest();
    thr = rest + int'($urandom_range(500, 4000));
    set_config(rest, rest + int'($urandom_range(0, 1500)), thr, $urandom_range(2000, 30000),
               $urandom_range(0, 6), -32768 + int'($urandom_range(0, 4000)),
               thr + int'($urandom_range(0, 5000)));
    run_phase(180, 1'b1, 1'b1, 1'b0);

    set_config($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 255),
               $urandom, $urandom);
    run_phase(180, 1'b1, 1'b0, 1'b1);

    rest = bio_rest();
    thr = rest + int'($urandom_range(500, 4000));
    set_config(rest, rest - int'($urandom_range(0, 1500)), thr, $urandom_range(20000, 65535),
               $urandom_range(1, 3), rest - int'($urandom_range(2000, 8000)),
               thr + int'($urandom_range(0, 5000)));
    run_phase(180, 1'b1, 1'b0, 1'b0);

    set_config($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 255),
               $urandom, $urandom);
    run_phase(180, 1'b1, 1'b0, 1'b0);

    // Final stretch at full rate on both sides
    rest = bio_rest();
    thr = rest + int'($urandom_range(500, 4000));
    set_config(rest, rest + int'($urandom_range(0, 1500)), thr, $urandom_range(1000, 12000),
               $urandom_range(0, 5), -32768, thr + int'($urandom_range(0, 5000)));
    run_phase(180, 1'b0, 1'b0, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Ran %0d requests (%0d from the directed table) over the reset, directed",
             n_requests, n_directed);
    $display("and eight random register settings; checked %0d results, %0d spikes, %0d %s",
             n_results, spike_count, n_reg_writes, "register writes");
    if (n_errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
